@@ design/strict_utf8_text_validator_core_defines.svh @@
// Assertion macros shared by the strict UTF-8 validator RTL.
`ifndef STRICT_UTF8_TEXT_VALIDATOR_CORE_DEFINES_SVH
`define STRICT_UTF8_TEXT_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUTV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SUTV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sutv_pkg.sv @@
// Shared constants and types for the strict UTF-8 text validator.
`timescale 1ns / 1ps
`default_nettype none

package sutv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned ACCUM_W = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'h1FF;
    localparam logic [COUNT_W-1:0] MAX_LEN_RESET  = 9'd120;

    localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DEL        = 8'h7F;
    localparam logic [BYTE_W-1:0] ASCII_TOP       = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_LO        = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI        = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO        = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI        = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO        = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI        = 8'hF4;

    localparam logic [ACCUM_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [ACCUM_W-1:0] SURR_LO        = 21'h00D800;
    localparam logic [ACCUM_W-1:0] SURR_HI        = 21'h00DFFF;
    localparam logic [ACCUM_W-1:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [ACCUM_W-1:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [ACCUM_W-1:0] MIN_FOUR_BYTE  = 21'h010000;

    // Sequence length class: number of continuation bytes of the sequence.
    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } t_seq_class;

    typedef struct packed {
        logic [1:0]         pending;
        logic [ACCUM_W-1:0] accum;
        t_seq_class         seq_class;
        logic               failed;
        logic [COUNT_W-1:0] len_count;
        logic               saw_non_space;
    } t_decode_state;

endpackage

`default_nettype wire

@@ design/sutv_in_if.sv @@
// Input channel: one text byte or an end marker per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface sutv_in_if;
    logic                       valid;
    logic                       ready;
    logic [sutv_pkg::BYTE_W-1:0] text_byte;
    logic                       end_marker;

    modport source (output valid, output text_byte, output end_marker, input ready);
    modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

`default_nettype wire

@@ design/sutv_out_if.sv @@
// Output channel: one verdict per finished string.
`timescale 1ns / 1ps
`default_nettype none

interface sutv_out_if;
    logic                        valid;
    logic                        ready;
    logic                        valid_res;
    logic [sutv_pkg::COUNT_W-1:0] byte_count;

    modport source (output valid, output valid_res, output byte_count, input ready);
    modport sink   (input valid, input valid_res, input byte_count, output ready);
endinterface

`default_nettype wire

@@ design/strict_utf8_text_validator_core.sv @@
// Strict UTF-8 string validator, one byte per cycle while i_text.ready is high.
// Usage:
//   i_text carries one item per transfer: a text byte (end_marker low) or an
//   end marker (end_marker high, text_byte ignored). Byte items produce no
//   output; each end marker produces one transfer on o_verdict holding the
//   pass/fail verdict for the string and its byte count (saturating at 511).
//   i_cfg_we/i_cfg_wdata load max_length; write it only between strings.
// Throughput:
//   One item is taken per cycle while i_text.ready is high. The decode state
//   is a single register bank updated by shallow compare/shift logic, so the
//   verdict appears on o_verdict in the cycle after the end marker transfer.
// Reset:
//   i_rst_n (synchronous, low) clears the decode state and output valid and
//   sets max_length to 120.
// Stall:
//   The verdict sits in an output register. While it is held and
//   o_verdict.ready is low, i_text.ready is low for every item, bytes too,
//   so a second end marker cannot overwrite it.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_utf8_text_validator_core_defines.svh"

module strict_utf8_text_validator_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [sutv_pkg::BYTE_W-1:0]     i_cfg_wdata,
    sutv_in_if.sink                        i_text,
    sutv_out_if.source                     o_verdict
);

    sutv_pkg::t_decode_state               r_st, n_st;
    logic [sutv_pkg::BYTE_W-1:0]           r_max_len;
    logic                                  r_out_valid, n_out_valid;
    logic                                  r_valid_res, n_valid_res;
    logic [sutv_pkg::COUNT_W-1:0]          r_byte_count, n_byte_count;

    logic                                  in_xfer;
    logic                                  out_xfer;
    logic [sutv_pkg::BYTE_W-1:0]           b;
    logic [sutv_pkg::ACCUM_W-1:0]          cont_accum;
    logic [1:0]                            cont_pending;
    logic [sutv_pkg::ACCUM_W-1:0]          class_min;
    logic                                  verdict;

    assign in_xfer  = i_text.valid && i_text.ready;
    assign out_xfer = r_out_valid && o_verdict.ready;
    assign b        = i_text.text_byte;

    assign i_text.ready         = !r_out_valid || o_verdict.ready;
    assign o_verdict.valid      = r_out_valid;
    assign o_verdict.valid_res  = r_valid_res;
    assign o_verdict.byte_count = r_byte_count;

    assign cont_accum   = {r_st.accum[sutv_pkg::ACCUM_W-7:0], b[5:0]};
    assign cont_pending = r_st.pending - 2'd1;

    always_comb begin
        unique case (r_st.seq_class)
            sutv_pkg::SEQ_TWO:   class_min = sutv_pkg::MIN_TWO_BYTE;
            sutv_pkg::SEQ_THREE: class_min = sutv_pkg::MIN_THREE_BYTE;
            default:             class_min = sutv_pkg::MIN_FOUR_BYTE;
        endcase
    end

    assign verdict = !r_st.failed && (r_st.pending == 2'd0)
                  && (r_st.len_count != '0)
                  && (r_st.len_count <= {1'b0, r_max_len})
                  && r_st.saw_non_space;

    always_comb begin
        n_st         = r_st;
        n_out_valid  = r_out_valid;
        n_valid_res  = r_valid_res;
        n_byte_count = r_byte_count;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        if (in_xfer && i_text.end_marker) begin
            n_out_valid  = 1'b1;
            n_valid_res  = verdict;
            n_byte_count = r_st.len_count;
            n_st         = '0;
        end else if (in_xfer) begin
            if (r_st.len_count != sutv_pkg::COUNT_MAX) begin
                n_st.len_count = r_st.len_count + 1'b1;
            end
            if (b != sutv_pkg::CHAR_SPACE) begin
                n_st.saw_non_space = 1'b1;
            end
            if (!r_st.failed) begin
                if (r_st.pending == 2'd0) begin
                    // lead byte or plain ASCII
                    if (b < sutv_pkg::CHAR_SPACE || b == sutv_pkg::CHAR_DEL) begin
                        n_st.failed = 1'b1;
                    end else if (b < sutv_pkg::ASCII_TOP) begin
                        n_st.failed = 1'b0;
                    end else if (b >= sutv_pkg::LEAD2_LO && b <= sutv_pkg::LEAD2_HI) begin
                        n_st.seq_class = sutv_pkg::SEQ_TWO;
                        n_st.pending   = 2'd1;
                        n_st.accum     = {16'd0, b[4:0]};
                    end else if (b >= sutv_pkg::LEAD3_LO && b <= sutv_pkg::LEAD3_HI) begin
                        n_st.seq_class = sutv_pkg::SEQ_THREE;
                        n_st.pending   = 2'd2;
                        n_st.accum     = {17'd0, b[3:0]};
                    end else if (b >= sutv_pkg::LEAD4_LO && b <= sutv_pkg::LEAD4_HI) begin
                        n_st.seq_class = sutv_pkg::SEQ_FOUR;
                        n_st.pending   = 2'd3;
                        n_st.accum     = {18'd0, b[2:0]};
                    end else begin
                        n_st.failed = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    n_st.failed = 1'b1;
                end else if (cont_pending != 2'd0) begin
                    n_st.accum   = cont_accum;
                    n_st.pending = cont_pending;
                end else begin
                    // last continuation: range-check the finished code point
                    n_st.pending   = 2'd0;
                    n_st.accum     = '0;
                    n_st.seq_class = sutv_pkg::SEQ_NONE;
                    if (cont_accum < class_min || cont_accum > sutv_pkg::CP_MAX
                        || (cont_accum >= sutv_pkg::SURR_LO
                            && cont_accum <= sutv_pkg::SURR_HI)) begin
                        n_st.failed = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
            r_max_len   <= sutv_pkg::MAX_LEN_RESET[sutv_pkg::BYTE_W-1:0];
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid_res  <= n_valid_res;
        r_byte_count <= n_byte_count;
    end

    `SUTV_ASSERT_NOW(a_pending_has_class, i_clk, i_rst_n,
        r_st.pending != 2'd0, r_st.seq_class != sutv_pkg::SEQ_NONE,
        "continuations pending without a sequence class")
    `SUTV_ASSERT_NEXT(a_end_gives_verdict, i_clk, i_rst_n,
        in_xfer && i_text.end_marker,
        o_verdict.valid && o_verdict.byte_count == $past(r_st.len_count)
            && r_st.len_count == '0,
        "end marker did not load verdict or clear the string")
    `SUTV_ASSERT_NEXT(a_byte_no_result, i_clk, i_rst_n,
        in_xfer && !i_text.end_marker && !r_out_valid, !o_verdict.valid,
        "byte item produced a verdict")
    `SUTV_ASSERT_NEXT(a_count_saturates, i_clk, i_rst_n,
        in_xfer && !i_text.end_marker && r_st.len_count == sutv_pkg::COUNT_MAX,
        r_st.len_count == sutv_pkg::COUNT_MAX,
        "byte count wrapped past saturation")

endmodule

`default_nettype wire
